[rtl/stlf_pkg.sv]
// Shared types and constants for the set-associative tag lookup block.
// No dependencies; the top level, controller and datapath import this package.
package stlf_pkg;

    // Fixed field widths of the input word and the result word.
    localparam int ADDR_BITS     = 8;
    localparam int WAY_OUT_BITS  = 2;
    localparam int SET_OUT_BITS  = 2;
    localparam int TAG_OUT_BITS  = 5;
    localparam int COUNT_BITS    = 32;

    // Address split: offset at the bottom, set bits above it, tag on top.
    localparam int SET_COUNT     = 4;
    localparam int OFFSET_BITS   = 1;
    localparam int SET_BITS      = $clog2(SET_COUNT);
    localparam int ADDR_TAG_BITS = ADDR_BITS - OFFSET_BITS - SET_BITS;

    // Defaults for the top-level parameters.
    localparam int WAYS_DEFAULT     = 4;
    localparam int TAG_BITS_DEFAULT = 5;

    // Input word.
    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
    } lookup_t;

    // Result word.
    typedef struct packed {
        logic                    hit;
        logic [WAY_OUT_BITS-1:0] way;
        logic [SET_OUT_BITS-1:0] set_index;
        logic [TAG_OUT_BITS-1:0] tag_value;
        logic [COUNT_BITS-1:0]   hits_total;
        logic [COUNT_BITS-1:0]   misses_total;
    } result_t;

    // Controller states.
    typedef enum logic {
        ST_WAIT_IN,
        ST_LOOKUP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_addr;
        logic commit;
    } cmd_t;

endpackage

[rtl/stlf_stream_if.sv]
// Valid/ready stream channel carrying one word of a chosen payload type.
// No dependencies; the payload type is given where the channel is declared.
interface stlf_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/set_assoc_tag_lookup_fifo.sv]
// Set-associative tag lookup with round-robin replacement.
//
// Usage:
//   lookup (sink) takes one word per access: an 8-bit byte address, bits
//   7..3 tag, bits 2..1 set, bit 0 offset (ignored).
//   result (source) returns one word per access: hit flag, the way that
//   hit or the way just filled, the set, the tag, and the running hit and
//   miss totals, both saturating at 2^32-1 and including this access.
//   On a miss the tag is written into the set's victim way, which is then
//   marked valid, and the set's victim pointer moves on by one way.
// Timing:
//   An address is registered in the cycle it is accepted; the compare and
//   directory update run in the lookup state and load the result register
//   once it can take a result. No new address is taken until that lookup
//   has committed. A new address is accepted while a result still waits;
//   if the receiver stalls, that lookup holds until the result register
//   frees, and lookup.ready stays low meanwhile.
//   Reset clears all valid bits, victim pointers and both counters at once.
// Depends on stlf_pkg, stlf_stream_if, stlf_ctrl and stlf_datapath.
module set_assoc_tag_lookup_fifo #(
    parameter int WAYS     = stlf_pkg::WAYS_DEFAULT,
    parameter int TAG_BITS = stlf_pkg::TAG_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    stlf_stream_if.sink   lookup,
    stlf_stream_if.source result
);
    import stlf_pkg::*;

    cmd_t cmd;

    // Sequencing of acceptance, lookup and output.
    stlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lookup.valid),
        .in_ready  (lookup.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Directory, counters and result register.
    stlf_datapath #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (lookup.data),
        .out_data (result.data)
    );

endmodule

[rtl/stlf_ctrl.sv]
// Controller of the tag lookup block: input acceptance, lookup commit and
// the output register's full flag. Depends on stlf_pkg.
module stlf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output stlf_pkg::cmd_t     cmd
);
    import stlf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_full_reg;
    logic   out_full_next;
    logic   can_commit;

    // The output register can take a result when it is empty or drains now.
    assign can_commit = !out_full_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WAIT_IN:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (can_commit)
                begin
                    state_next = ST_WAIT_IN;
                end
            end
            default:
            begin
                state_next = ST_WAIT_IN;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_addr = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_WAIT_IN:
            begin
                in_ready      = 1'b1;
                cmd.load_addr = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.commit = can_commit;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_full_next = out_full_reg;
        if (cmd.commit)
        begin
            out_full_next = 1'b1;
        end
        else if (out_full_reg && out_ready)
        begin
            out_full_next = 1'b0;
        end
    end

    assign out_valid = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_WAIT_IN;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

[rtl/stlf_datapath.sv]
// Datapath of the tag lookup block: address register, tag directory with
// valid bits, victim pointers, saturating counters and result register.
// Depends on stlf_pkg.
module stlf_datapath #(
    parameter int WAYS     = stlf_pkg::WAYS_DEFAULT,
    parameter int TAG_BITS = stlf_pkg::TAG_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stlf_pkg::cmd_t    cmd,
    input  stlf_pkg::lookup_t in_data,
    output stlf_pkg::result_t out_data
);
    import stlf_pkg::*;

    localparam int WAY_BITS = $clog2(WAYS);

    logic [ADDR_BITS-1:0]  addr_reg;
    logic [TAG_BITS-1:0]   tag_reg    [SET_COUNT][WAYS];
    logic                  valid_reg  [SET_COUNT][WAYS];
    logic [WAY_BITS-1:0]   victim_reg [SET_COUNT];
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic [COUNT_BITS-1:0] miss_cnt_reg;
    result_t               result_reg;

    logic [SET_BITS-1:0]               set_sel;
    logic [ADDR_TAG_BITS+TAG_BITS-1:0] tag_wide;
    logic [TAG_BITS-1:0]               tag_sel;
    logic                              hit;
    logic [WAY_BITS-1:0]               hit_way;
    logic [WAY_BITS-1:0]               victim;
    logic [WAY_BITS-1:0]               victim_next;
    logic [WAY_BITS-1:0]               way_sel;
    logic [COUNT_BITS-1:0]             hit_cnt_next;
    logic [COUNT_BITS-1:0]             miss_cnt_next;
    logic [WAY_BITS+WAY_OUT_BITS-1:0]  way_wide;
    logic [TAG_BITS+TAG_OUT_BITS-1:0]  tag_out_wide;
    logic [SET_BITS+SET_OUT_BITS-1:0]  set_wide;

    // Split the held address; tag bits beyond the address read as zero.
    assign set_sel  = addr_reg[OFFSET_BITS +: SET_BITS];
    assign tag_wide = {{TAG_BITS{1'b0}}, addr_reg[ADDR_BITS-1 -: ADDR_TAG_BITS]};
    assign tag_sel  = tag_wide[TAG_BITS-1:0];

    // Compare against every way of the set; the lowest matching way wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[set_sel][w] && (tag_reg[set_sel][w] == tag_sel))
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    // Round-robin victim pointer, wrapping after the last way.
    assign victim      = victim_reg[set_sel];
    assign victim_next = (victim == WAY_BITS'(WAYS - 1)) ? '0 : victim + 1'b1;
    assign way_sel     = hit ? hit_way : victim;

    // Counters stop at their maximum value.
    assign hit_cnt_next  = (hit && !(&hit_cnt_reg)) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
    assign miss_cnt_next = (!hit && !(&miss_cnt_reg)) ? miss_cnt_reg + 1'b1 : miss_cnt_reg;

    // Fit way, set and tag to the result field widths.
    assign way_wide     = {{WAY_OUT_BITS{1'b0}}, way_sel};
    assign tag_out_wide = {{TAG_OUT_BITS{1'b0}}, tag_sel};
    assign set_wide     = {{SET_OUT_BITS{1'b0}}, set_sel};

    // Address register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_addr)
        begin
            addr_reg <= in_data.address;
        end
    end

    // Tag storage and result register hold payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (!hit)
            begin
                tag_reg[set_sel][victim] <= tag_sel;
            end
            result_reg.hit          <= hit;
            result_reg.way          <= way_wide[WAY_OUT_BITS-1:0];
            result_reg.set_index    <= set_wide[SET_OUT_BITS-1:0];
            result_reg.tag_value    <= tag_out_wide[TAG_OUT_BITS-1:0];
            result_reg.hits_total   <= hit_cnt_next;
            result_reg.misses_total <= miss_cnt_next;
        end
    end

    // Valid bits, victim pointers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SET_COUNT; s++)
            begin
                victim_reg[s] <= '0;
                for (int w = 0; w < WAYS; w++)
                begin
                    valid_reg[s][w] <= 1'b0;
                end
            end
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (!hit)
            begin
                valid_reg[set_sel][victim] <= 1'b1;
                victim_reg[set_sel]        <= victim_next;
            end
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    assign out_data = result_reg;

endmodule
